@@ rtl/core/lmt_pkg.sv @@
package lmt_pkg;

   localparam int VisibleLinesDefault = 144;
   localparam int TotalLinesDefault   = 154;

   localparam int SampleWidth = 16;
   localparam int AccWidth    = 18;
   localparam int LineWidth   = 8;
   localparam int CycWidth    = 9;

   localparam logic [CycWidth-1:0] OAM_CYCLES    = 9'd80;
   localparam logic [CycWidth-1:0] XFER_CYCLES   = 9'd172;
   localparam logic [CycWidth-1:0] HBLANK_CYCLES = 9'd204;
   localparam logic [CycWidth-1:0] LINE_CYCLES   = 9'd456;
   localparam logic [AccWidth-1:0] ACC_MAX       = {AccWidth{1'b1}};

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_COMPARE_LINE    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STAT_INT_ENABLE = 2'd1;

   // stat_int_enable bit positions
   localparam int EN_HBLANK = 0;
   localparam int EN_VBLANK = 1;
   localparam int EN_OAM    = 2;
   localparam int EN_COIN   = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               lcd_mode;
      logic [LineWidth-1:0]   current_line;
      logic                   coincidence;
      logic                   draw_line_pulse;
      logic                   vblank_irq;
      logic                   stat_irq;
      logic                   clear_vblank_request;
   } lmt_result_type;

endpackage

@@ rtl/core/lmt_delta_stage.sv @@
module lmt_delta_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [lmt_pkg::SampleWidth-1:0]    in_sample,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [lmt_pkg::SampleWidth-1:0]    out_delta
);
   import lmt_pkg::*;

   logic                   valid_ff, valid_in;
   logic [SampleWidth-1:0] last_sample_ff, last_sample_in;
   logic [SampleWidth-1:0] delta_ff, delta_in;
   logic                   in_fire;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      valid_in       = valid_ff;
      last_sample_in = last_sample_ff;
      delta_in       = delta_ff;
      if (in_fire) begin
         valid_in       = 1'b1;
         last_sample_in = in_sample;
         // modulo 2^16 difference falls out of the fixed width
         delta_in       = in_sample - last_sample_ff;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         last_sample_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         last_sample_ff <= last_sample_in;
      end
      delta_ff <= delta_in;
   end

   assign out_valid = valid_ff;
   assign out_delta = delta_ff;

endmodule

@@ rtl/core/lmt_mode_core.sv @@
module lmt_mode_core #(
   parameter int VISIBLE_LINES = lmt_pkg::VisibleLinesDefault,
   parameter int TOTAL_LINES   = lmt_pkg::TotalLinesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [lmt_pkg::SampleWidth-1:0]   delta,
   input  logic [lmt_pkg::LineWidth-1:0]     compare_line,
   input  logic [3:0]                        stat_int_enable,
   output lmt_pkg::lmt_result_type           result
);
   import lmt_pkg::*;

   localparam logic [LineWidth-1:0] VisLine   = LineWidth'(VISIBLE_LINES);
   localparam logic [LineWidth:0]   TotalLine = (LineWidth+1)'(TOTAL_LINES);

   logic [AccWidth-1:0]  acc_ff, acc_in;
   mode_type             mode_ff, mode_in;
   logic [LineWidth-1:0] line_ff, line_in;
   logic                 coin_ff, coin_in;
   logic                 cond_ff, cond_in;

   logic [AccWidth:0]    acc_sum;
   logic [AccWidth-1:0]  acc_sat;
   logic [CycWidth-1:0]  thresh;
   logic                 done;
   logic [LineWidth:0]   line_inc;
   logic                 line_chg;
   logic                 draw, vbl, clr;

   always_comb begin
      acc_sum = {1'b0, acc_ff} + {{(AccWidth+1-SampleWidth){1'b0}}, delta};
      acc_sat = acc_sum[AccWidth] ? ACC_MAX : acc_sum[AccWidth-1:0];
      case (mode_ff)
         MODE_OAM:    thresh = OAM_CYCLES;
         MODE_XFER:   thresh = XFER_CYCLES;
         MODE_HBLANK: thresh = HBLANK_CYCLES;
         default:     thresh = LINE_CYCLES;
      endcase
      done     = acc_sat >= {{(AccWidth-CycWidth){1'b0}}, thresh};
      line_inc = {1'b0, line_ff} + {{LineWidth{1'b0}}, 1'b1};

      acc_in   = done ? acc_sat - {{(AccWidth-CycWidth){1'b0}}, thresh} : acc_sat;
      mode_in  = mode_ff;
      line_in  = line_ff;
      line_chg = 1'b0;
      draw     = 1'b0;
      vbl      = 1'b0;
      clr      = 1'b0;
      if (done) begin
         case (mode_ff)
            MODE_OAM: begin
               mode_in = MODE_XFER;
            end
            MODE_XFER: begin
               mode_in = MODE_HBLANK;
               draw    = 1'b1;
            end
            MODE_HBLANK: begin
               line_in  = line_inc[LineWidth-1:0];
               line_chg = 1'b1;
               if (line_inc[LineWidth-1:0] == VisLine) begin
                  mode_in = MODE_VBLANK;
                  vbl     = 1'b1;
               end else begin
                  mode_in = MODE_OAM;
               end
            end
            default: begin
               line_chg = 1'b1;
               if (line_inc >= TotalLine) begin
                  line_in = '0;
                  mode_in = MODE_OAM;
                  clr     = 1'b1;
               end else begin
                  line_in = line_inc[LineWidth-1:0];
               end
            end
         endcase
      end

      // flag only refreshes when the line moves
      coin_in = line_chg ? (line_in == compare_line) : coin_ff;

      cond_in = (stat_int_enable[EN_COIN] && coin_in) ||
                (stat_int_enable[EN_HBLANK] && mode_in == MODE_HBLANK) ||
                (stat_int_enable[EN_OAM] && mode_in == MODE_OAM) ||
                ((stat_int_enable[EN_VBLANK] || stat_int_enable[EN_OAM]) &&
                 mode_in == MODE_VBLANK);

      result.lcd_mode             = mode_in;
      result.current_line         = line_in;
      result.coincidence          = coin_in;
      result.draw_line_pulse      = draw;
      result.vblank_irq           = vbl;
      result.stat_irq             = cond_in && !cond_ff;
      result.clear_vblank_request = clr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         mode_ff <= MODE_OAM;
         line_ff <= '0;
         coin_ff <= 1'b0;
         cond_ff <= 1'b0;
      end else if (step) begin
         acc_ff  <= acc_in;
         mode_ff <= mode_in;
         line_ff <= line_in;
         coin_ff <= coin_in;
         cond_ff <= cond_in;
      end
   end

   a_draw_to_hblank: assert property (@(posedge clock) disable iff (reset)
      step && draw |=> mode_ff == MODE_HBLANK)
      else $error("draw pulse without entering hblank");

   a_vbl_entry: assert property (@(posedge clock) disable iff (reset)
      step && vbl |=> mode_ff == MODE_VBLANK && line_ff == VisLine)
      else $error("vblank entry at wrong line");

   a_wrap_to_oam: assert property (@(posedge clock) disable iff (reset)
      step && clr |=> mode_ff == MODE_OAM && line_ff == '0)
      else $error("frame wrap did not restart at line 0");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(acc_ff) && $stable(mode_ff) && $stable(line_ff))
      else $error("timing state moved without a word");

endmodule

@@ rtl/core/lcd_mode_timing_stat_irq_unit.sv @@
// Path from req accept to rsp_valid: delta register, then result register.
// One word per cycle when rsp_ready is high; one more can wait in the delta stage.
// The accumulator/mode/line update for one word is combinational in the core.
// Reset (synchronous, active high): mode OAM search, line 0, accumulator, last sample,
// flags and both CSRs cleared; no pipeline words held.
module lcd_mode_timing_stat_irq_unit #(
   parameter int VISIBLE_LINES = lmt_pkg::VisibleLinesDefault,
   parameter int TOTAL_LINES   = lmt_pkg::TotalLinesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lmt_pkg::SampleWidth-1:0]      req_cpu_cycle_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_lcd_mode,
   output logic [lmt_pkg::LineWidth-1:0]        rsp_current_line,
   output logic                                 rsp_coincidence,
   output logic                                 rsp_draw_line_pulse,
   output logic                                 rsp_vblank_irq,
   output logic                                 rsp_stat_irq,
   output logic                                 rsp_clear_vblank_request,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lmt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [lmt_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import lmt_pkg::*;

   logic [LineWidth-1:0]   compare_line_ff, compare_line_in;
   logic [3:0]             stat_en_ff, stat_en_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lmt_result_type         rsp_data_ff, rsp_data_in;

   logic                   d_valid;
   logic [SampleWidth-1:0] d_delta;
   logic                   out_ready;
   logic                   step;
   lmt_result_type         core_result;

   assign csr_ready = 1'b1;
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign step      = d_valid && out_ready;

   lmt_delta_stage u_delta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_cpu_cycle_count),
      .out_valid (d_valid),
      .out_ready (out_ready),
      .out_delta (d_delta)
   );

   lmt_mode_core #(
      .VISIBLE_LINES (VISIBLE_LINES),
      .TOTAL_LINES   (TOTAL_LINES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .delta           (d_delta),
      .compare_line    (compare_line_ff),
      .stat_int_enable (stat_en_ff),
      .result          (core_result)
   );

   always_comb begin
      compare_line_in = compare_line_ff;
      stat_en_in      = stat_en_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMPARE_LINE:    compare_line_in = csr_wdata[LineWidth-1:0];
            CSR_STAT_INT_ENABLE: stat_en_in      = csr_wdata[3:0];
            default:             ;
         endcase
      end

      rsp_data_in  = step ? core_result : rsp_data_ff;
      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_line_ff <= '0;
         stat_en_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         compare_line_ff <= compare_line_in;
         stat_en_ff      <= stat_en_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_lcd_mode             = rsp_data_ff.lcd_mode;
   assign rsp_current_line         = rsp_data_ff.current_line;
   assign rsp_coincidence          = rsp_data_ff.coincidence;
   assign rsp_draw_line_pulse      = rsp_data_ff.draw_line_pulse;
   assign rsp_vblank_irq           = rsp_data_ff.vblank_irq;
   assign rsp_stat_irq             = rsp_data_ff.stat_irq;
   assign rsp_clear_vblank_request = rsp_data_ff.clear_vblank_request;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;
   import lmt_pkg::*;

   // indexes 2 and 3 decode to nothing
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_3 = 2'd3;
   localparam int PhaseItems = 88;
   localparam int PhaseCount = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SampleWidth-1:0]   req_cpu_cycle_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_lcd_mode;
   logic [LineWidth-1:0]     rsp_current_line;
   logic                     rsp_coincidence;
   logic                     rsp_draw_line_pulse;
   logic                     rsp_vblank_irq;
   logic                     rsp_stat_irq;
   logic                     rsp_clear_vblank_request;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   // display model state
   logic [SampleWidth-1:0] last_sample_q = '0;
   logic [AccWidth-1:0]    acc_q = '0;
   mode_type               mode_q = MODE_OAM;
   logic [LineWidth-1:0]   line_q = '0;
   logic                   coin_q = 1'b0;
   logic                   stat_prev_q = 1'b0;
   logic [LineWidth-1:0]   cmp_line_q = '0;
   logic [3:0]             stat_en_q = '0;

   lmt_result_type         expected_status[$];
   logic [SampleWidth-1:0] last_sent = '0;
   int                     gap_pct = 0;
   int                     stall_pct = 0;
   int                     mismatch_count = 0;

   always #6 clock = ~clock;

   lcd_mode_timing_stat_irq_unit dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_cpu_cycle_count      (req_cpu_cycle_count),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_lcd_mode             (rsp_lcd_mode),
      .rsp_current_line         (rsp_current_line),
      .rsp_coincidence          (rsp_coincidence),
      .rsp_draw_line_pulse      (rsp_draw_line_pulse),
      .rsp_vblank_irq           (rsp_vblank_irq),
      .rsp_stat_irq             (rsp_stat_irq),
      .rsp_clear_vblank_request (rsp_clear_vblank_request),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   function automatic void enter_line(logic [LineWidth-1:0] n);
      line_q = n;
      coin_q = (n == cmp_line_q);
   endfunction

   function automatic lmt_result_type predict_lcd_step(logic [SampleWidth-1:0] sample);
      lmt_result_type         r;
      logic [SampleWidth-1:0] delta;
      logic [AccWidth:0]      sum;
      logic                   cond;
      r = '0;
      delta = sample - last_sample_q;
      last_sample_q = sample;
      sum = {1'b0, acc_q} + delta;
      acc_q = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[AccWidth-1:0];
      // one mode change per word at most; surplus stays in the accumulator
      case (mode_q)
         MODE_OAM: if (acc_q >= OAM_CYCLES) begin
            acc_q = acc_q - OAM_CYCLES;
            mode_q = MODE_XFER;
         end
         MODE_XFER: if (acc_q >= XFER_CYCLES) begin
            acc_q = acc_q - XFER_CYCLES;
            r.draw_line_pulse = 1'b1;
            mode_q = MODE_HBLANK;
         end
         MODE_HBLANK: if (acc_q >= HBLANK_CYCLES) begin
            acc_q = acc_q - HBLANK_CYCLES;
            enter_line(line_q + 8'd1);
            if (line_q == VisibleLinesDefault) begin
               r.vblank_irq = 1'b1;
               mode_q = MODE_VBLANK;
            end else begin
               mode_q = MODE_OAM;
            end
         end
         default: if (acc_q >= LINE_CYCLES) begin
            acc_q = acc_q - LINE_CYCLES;
            if (int'(line_q) + 1 >= TotalLinesDefault) begin
               enter_line('0);
               mode_q = MODE_OAM;
               r.clear_vblank_request = 1'b1;
            end else begin
               enter_line(line_q + 8'd1);
            end
         end
      endcase
      // oam enable also fires in vblank
      cond = (stat_en_q[EN_COIN] && coin_q) ||
             (stat_en_q[EN_HBLANK] && mode_q == MODE_HBLANK) ||
             (stat_en_q[EN_OAM] && mode_q == MODE_OAM) ||
             ((stat_en_q[EN_VBLANK] || stat_en_q[EN_OAM]) && mode_q == MODE_VBLANK);
      r.stat_irq = cond && !stat_prev_q;
      stat_prev_q = cond;
      r.lcd_mode = mode_q;
      r.current_line = line_q;
      r.coincidence = coin_q;
      return r;
   endfunction

   task automatic send_count(input logic [SampleWidth-1:0] sample);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cpu_cycle_count <= sample;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(predict_lcd_step(sample));
      last_sent = sample;
   endtask

   task automatic send_delta(input logic [SampleWidth-1:0] delta);
      send_count(last_sent + delta);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COMPARE_LINE:    cmp_line_q = data;
         CSR_STAT_INT_ENABLE: stat_en_q = data[3:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      lmt_result_type got;
      lmt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.lcd_mode = mode_type'(rsp_lcd_mode);
         got.current_line = rsp_current_line;
         got.coincidence = rsp_coincidence;
         got.draw_line_pulse = rsp_draw_line_pulse;
         got.vblank_irq = rsp_vblank_irq;
         got.stat_irq = rsp_stat_irq;
         got.clear_vblank_request = rsp_clear_vblank_request;
         if (expected_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: unexpected word mode %0d line %0d coin %b", got.lcd_mode,
                        got.current_line, got.coincidence);
         end else begin
            want = expected_status.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("expected mode %0d line %0d coin %b draw %b vbl %b stat %b clr %b",
                           want.lcd_mode, want.current_line, want.coincidence,
                           want.draw_line_pulse, want.vblank_irq, want.stat_irq,
                           want.clear_vblank_request);
                  $display("     got mode %0d line %0d coin %b draw %b vbl %b stat %b clr %b",
                           got.lcd_mode, got.current_line, got.coincidence,
                           got.draw_line_pulse, got.vblank_irq, got.stat_irq,
                           got.clear_vblank_request);
               end
            end
         end
      end
   end

   // flag is not computed at reset, and a compare write alone leaves it alone
   task automatic test_reset_values();
      send_count('0);
      wait_drain();
      write_csr(CSR_COMPARE_LINE, 8'd0);
      send_delta(16'd0);
      wait_drain();
   endtask

   // step oam, transfer and hblank exactly at and just below their lengths
   task automatic test_mode_walk();
      write_csr(CSR_STAT_INT_ENABLE, 8'hFF);
      write_csr(CSR_COMPARE_LINE, 8'd1);
      write_csr(CSR_SPARE_2, 8'($urandom));
      write_csr(CSR_SPARE_3, 8'($urandom));
      send_delta(16'd79);
      send_delta(16'd1);
      send_delta(16'd171);
      send_delta(16'd1);
      send_delta(16'd203);
      send_delta(16'd1);
      send_delta(16'd80);
      send_delta(16'd172);
      send_delta(16'd204);
   endtask

   task automatic test_count_extremes();
      send_count(16'hFFFF);
      send_count(16'h0000);
   endtask

   task automatic test_saturation();
      repeat (6) send_delta(16'hFFFF);
      send_delta(16'd0);
   endtask

   task automatic test_random_phase(input int phase);
      int                     thr;
      int                     need;
      int                     pick;
      int                     cmp;
      logic [3:0]             en;
      logic [SampleWidth-1:0] delta;
      wait_drain();
      case (phase % 4)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 62; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 62; end
         default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      if (phase == 0) begin
         cmp = 255;
         en = 4'h0;
      end else if (phase == 1) begin
         cmp = 0;
         en = 4'hF;
      end else begin
         // aim the compare a few lines ahead so coincidence shows up
         cmp = int'(line_q) + $urandom_range(1, 12);
         if (cmp >= TotalLinesDefault) cmp -= TotalLinesDefault;
         if (line_q >= 100)
            en = $urandom_range(0, 1) ? 4'(1 << EN_OAM) : 4'(1 << EN_VBLANK);
         else
            en = 4'($urandom_range(0, 15));
      end
      write_csr(CSR_COMPARE_LINE, 8'(cmp));
      write_csr(CSR_STAT_INT_ENABLE, {4'($urandom), en});
      for (int i = 0; i < PhaseItems; i++) begin
         case (mode_q)
            MODE_OAM:    thr = OAM_CYCLES;
            MODE_XFER:   thr = XFER_CYCLES;
            MODE_HBLANK: thr = HBLANK_CYCLES;
            default:     thr = LINE_CYCLES;
         endcase
         need = (int'(acc_q) < thr) ? thr - int'(acc_q) : 0;
         pick = $urandom_range(0, 99);
         if (pick < 75)
            delta = 16'(need + $urandom_range(0, 40));
         else if (pick < 90)
            delta = (need > 0) ? 16'($urandom_range(0, need - 1)) : 16'd0;
         else
            delta = 16'($urandom_range(0, 1500));
         if (phase == 2 && i == PhaseItems / 2) wait_drain();
         send_delta(delta);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_mode_walk();
      test_count_extremes();
      for (int p = 0; p < PhaseCount; p++) test_random_phase(p);
      wait_drain();
      gap_pct = 0;
      stall_pct = 0;
      test_saturation();
      wait_drain();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
